// ----- rtl/bqf_pkg.sv -----
// bqf_pkg: shared constants for the two-stage biquad filter
// default widths, the multiplier digit size and the register index codes
// no dependencies
package bqf_pkg;

   localparam int SAMPLE_WIDTH_DEF   = 16;
   localparam int COEF_WIDTH_DEF     = 18;
   localparam int COEF_FRAC_BITS_DEF = 14;
   localparam int STATE_WIDTH_DEF    = 24;

   // coefficient bits consumed by the serial multiplier per cycle
   localparam int DIGIT_WIDTH = 4;

   localparam int CSR_INDEX_WIDTH = 3;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_FEEDFORWARD_STAGE0 = 3'd0;
   localparam csr_index_type CSR_FEEDBACK_STAGE0    = 3'd1;
   localparam csr_index_type CSR_FEEDFORWARD_STAGE1 = 3'd2;
   localparam csr_index_type CSR_FEEDBACK_STAGE1    = 3'd3;

endpackage

// ----- rtl/bqf_mac.sv -----
// bqf_mac: digit-serial signed multiplier, coefficient shifted out msb digit first
// product = coef * data, accumulated digit by digit
// depends on bqf_pkg
module bqf_mac #(
   parameter int COEF_WIDTH  = bqf_pkg::COEF_WIDTH_DEF,
   parameter int STATE_WIDTH = bqf_pkg::STATE_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [COEF_WIDTH-1:0]                  coef,
   input  logic signed [STATE_WIDTH-1:0]          data,
   output logic                                   done,
   output logic signed [STATE_WIDTH +
      ((COEF_WIDTH + bqf_pkg::DIGIT_WIDTH - 1) / bqf_pkg::DIGIT_WIDTH) *
      bqf_pkg::DIGIT_WIDTH - 1:0]                  product
);
   import bqf_pkg::*;

   localparam int NDIG  = (COEF_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
   localparam int CPAD  = NDIG * DIGIT_WIDTH;
   localparam int PW    = STATE_WIDTH + CPAD;
   localparam int CNT_W = $clog2(NDIG + 1);

   logic [CPAD-1:0]                coef_sr_ff, coef_sr_in;
   logic signed [STATE_WIDTH-1:0]  data_ff, data_in;
   logic signed [PW-1:0]           prod_ff, prod_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   logic [DIGIT_WIDTH-1:0]         digit;
   logic signed [DIGIT_WIDTH:0]    sdigit;
   logic signed [STATE_WIDTH+DIGIT_WIDTH:0] partial;

   // the top digit carries the sign, the rest are unsigned
   always_comb begin
      digit   = coef_sr_ff[CPAD-1 -: DIGIT_WIDTH];
      sdigit  = (cnt_ff == CNT_W'(NDIG)) ? {digit[DIGIT_WIDTH-1], digit} : {1'b0, digit};
      partial = sdigit * data_ff;
   end

   always_comb begin
      coef_sr_in = coef_sr_ff;
      data_in    = data_ff;
      prod_in    = prod_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         coef_sr_in = CPAD'($signed(coef));
         data_in    = data;
         prod_in    = '0;
         cnt_in     = CNT_W'(NDIG);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         prod_in    = (prod_ff <<< DIGIT_WIDTH) + PW'(partial);
         coef_sr_in = coef_sr_ff << DIGIT_WIDTH;
         cnt_in     = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      coef_sr_ff <= coef_sr_in;
      data_ff    <= data_in;
      prod_ff    <= prod_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

// ----- rtl/two_stage_biquad_filter.sv -----
// two_stage_biquad_filter: two cascaded direct-form-II biquad sections
// sequencer, accumulator, delay line and coefficient registers around bqf_mac
// depends on bqf_pkg and bqf_mac
//
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_stall   req_sample_in
//   rsp_      out         rsp_valid / rsp_stall   rsp_sample_out, rsp_saturated
//   csr_      in          csr_wr_en               csr_index, csr_wr_data
//
// the ten products of a transaction share one digit-serial multiplier
// reset clears the delay values and loads pass-through coefficients
// the result waits in the output register while rsp_stall is high, and the next
// transaction is taken as soon as the previous result has moved into it
module two_stage_biquad_filter #(
   parameter int SAMPLE_WIDTH   = bqf_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH     = bqf_pkg::COEF_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF,
   parameter int STATE_WIDTH    = bqf_pkg::STATE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]    req_sample_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]    rsp_sample_out,
   output logic                              rsp_saturated,
   input  logic                              csr_wr_en,
   input  bqf_pkg::csr_index_type            csr_index,
   input  logic [3*COEF_WIDTH-1:0]           csr_wr_data
);
   import bqf_pkg::*;

   localparam int XW   = (SAMPLE_WIDTH > STATE_WIDTH) ? SAMPLE_WIDTH : STATE_WIDTH;
   localparam int NDIG = (COEF_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
   localparam int CPAD = NDIG * DIGIT_WIDTH;
   localparam int PW   = STATE_WIDTH + CPAD;
   localparam int AW0  = (PW > XW + COEF_FRAC_BITS) ? PW : XW + COEF_FRAC_BITS;
   localparam int AW   = AW0 + 2;

   localparam logic signed [AW-1:0] ROUND_HALF =
      {{(AW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
   localparam logic signed [AW-1:0] STATE_HI =
      {{(AW-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
   localparam logic signed [AW-1:0] STATE_LO = ~STATE_HI;
   localparam logic signed [AW-1:0] SAMPLE_HI =
      {{(AW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [AW-1:0] SAMPLE_LO = ~SAMPLE_HI;
   localparam logic [3*COEF_WIDTH-1:0] FF_RESET =
      {{(3*COEF_WIDTH-1){1'b0}}, 1'b1} << COEF_FRAC_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_ACC  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam logic [2:0] TERM_A1 = 3'd0;
   localparam logic [2:0] TERM_A2 = 3'd1;
   localparam logic [2:0] TERM_B0 = 3'd2;
   localparam logic [2:0] TERM_B1 = 3'd3;
   localparam logic [2:0] TERM_B2 = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [2:0]                    term_ff, term_in;
   logic                          sec_ff, sec_in;
   logic                          sat_ff, sat_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_sat_ff, rsp_sat_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;
   logic signed [SAMPLE_WIDTH-1:0] res_ff, res_in;
   logic signed [AW-1:0]          acc_ff, acc_in;
   logic signed [STATE_WIDTH-1:0] w0_ff, w0_in;
   logic signed [STATE_WIDTH-1:0] delay_ff [4];
   logic signed [STATE_WIDTH-1:0] delay_in [4];
   logic [3*COEF_WIDTH-1:0]       ff0_ff, ff0_in, ff1_ff, ff1_in;
   logic [2*COEF_WIDTH-1:0]       fb0_ff, fb0_in, fb1_ff, fb1_in;

   logic                          mac_start;
   logic                          mac_done;
   logic [COEF_WIDTH-1:0]         mac_coef;
   logic signed [STATE_WIDTH-1:0] mac_data;
   logic signed [PW-1:0]          mac_product;

   logic [3*COEF_WIDTH-1:0]       ff_sel;
   logic [2*COEF_WIDTH-1:0]       fb_sel;
   logic signed [AW-1:0]          sum_acc;
   logic signed [AW-1:0]          rnd;
   logic                          st_clip_hi, st_clip_lo, sm_clip_hi, sm_clip_lo;
   logic signed [STATE_WIDTH-1:0] st_val;
   logic signed [SAMPLE_WIDTH-1:0] sm_val;

   bqf_mac #(
      .COEF_WIDTH  (COEF_WIDTH),
      .STATE_WIDTH (STATE_WIDTH)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .start   (mac_start),
      .coef    (mac_coef),
      .data    (mac_data),
      .done    (mac_done),
      .product (mac_product)
   );

   // operand selection; delays 0 and 1 always belong to the section at work
   always_comb begin
      ff_sel = sec_ff ? ff1_ff : ff0_ff;
      fb_sel = sec_ff ? fb1_ff : fb0_ff;
      unique case (term_ff)
         TERM_A1: begin
            mac_coef = fb_sel[0 +: COEF_WIDTH];
            mac_data = delay_ff[0];
         end
         TERM_A2: begin
            mac_coef = fb_sel[COEF_WIDTH +: COEF_WIDTH];
            mac_data = delay_ff[1];
         end
         TERM_B0: begin
            mac_coef = ff_sel[0 +: COEF_WIDTH];
            mac_data = w0_ff;
         end
         TERM_B1: begin
            mac_coef = ff_sel[COEF_WIDTH +: COEF_WIDTH];
            mac_data = delay_ff[0];
         end
         TERM_B2: begin
            mac_coef = ff_sel[2*COEF_WIDTH +: COEF_WIDTH];
            mac_data = delay_ff[1];
         end
         default: begin
            mac_coef = '0;
            mac_data = '0;
         end
      endcase
   end

   // round half up, then clamp to the state and sample ranges
   always_comb begin
      sum_acc    = acc_ff + AW'(mac_product);
      rnd        = (sum_acc + ROUND_HALF) >>> COEF_FRAC_BITS;
      st_clip_hi = rnd > STATE_HI;
      st_clip_lo = rnd < STATE_LO;
      sm_clip_hi = rnd > SAMPLE_HI;
      sm_clip_lo = rnd < SAMPLE_LO;
      if (st_clip_hi) begin
         st_val = STATE_HI[STATE_WIDTH-1:0];
      end else if (st_clip_lo) begin
         st_val = STATE_LO[STATE_WIDTH-1:0];
      end else begin
         st_val = rnd[STATE_WIDTH-1:0];
      end
      if (sm_clip_hi) begin
         sm_val = SAMPLE_HI[SAMPLE_WIDTH-1:0];
      end else if (sm_clip_lo) begin
         sm_val = SAMPLE_LO[SAMPLE_WIDTH-1:0];
      end else begin
         sm_val = rnd[SAMPLE_WIDTH-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      term_in       = term_ff;
      sec_in        = sec_ff;
      sat_in        = sat_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sat_in    = rsp_sat_ff;
      rsp_sample_in = rsp_sample_ff;
      res_in        = res_ff;
      acc_in        = acc_ff;
      w0_in         = w0_ff;
      delay_in      = delay_ff;
      ff0_in        = ff0_ff;
      ff1_in        = ff1_ff;
      fb0_in        = fb0_ff;
      fb1_in        = fb1_ff;
      mac_start     = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FEEDFORWARD_STAGE0: ff0_in = csr_wr_data;
            CSR_FEEDBACK_STAGE0:    fb0_in = csr_wr_data[2*COEF_WIDTH-1:0];
            CSR_FEEDFORWARD_STAGE1: ff1_in = csr_wr_data;
            CSR_FEEDBACK_STAGE1:    fb1_in = csr_wr_data[2*COEF_WIDTH-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               acc_in   = AW'(req_sample_in) <<< COEF_FRAC_BITS;
               sec_in   = 1'b0;
               term_in  = TERM_A1;
               sat_in   = 1'b0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            mac_start = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            if (mac_done) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            state_in = ST_LOAD;
            unique case (term_ff)
               TERM_A1, TERM_B0, TERM_B1: begin
                  acc_in  = sum_acc;
                  term_in = term_ff + 3'd1;
               end
               TERM_A2: begin
                  w0_in   = st_val;
                  sat_in  = sat_ff | st_clip_hi | st_clip_lo;
                  acc_in  = '0;
                  term_in = TERM_B0;
               end
               TERM_B2: begin
                  // rotate the delay line so the other section comes to the front
                  delay_in[0] = delay_ff[2];
                  delay_in[1] = delay_ff[3];
                  delay_in[2] = w0_ff;
                  delay_in[3] = delay_ff[0];
                  if (!sec_ff) begin
                     acc_in  = AW'(st_val) <<< COEF_FRAC_BITS;
                     sat_in  = sat_ff | st_clip_hi | st_clip_lo;
                     sec_in  = 1'b1;
                     term_in = TERM_A1;
                  end else begin
                     res_in   = sm_val;
                     sat_in   = sat_ff | sm_clip_hi | sm_clip_lo;
                     state_in = ST_DONE;
                  end
               end
               default: ;
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_sample_in = res_ff;
               rsp_sat_in    = sat_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= TERM_A1;
         sec_ff       <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         delay_ff     <= '{default: '0};
         ff0_ff       <= FF_RESET;
         ff1_ff       <= FF_RESET;
         fb0_ff       <= '0;
         fb1_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         sec_ff       <= sec_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
         delay_ff     <= delay_in;
         ff0_ff       <= ff0_in;
         ff1_ff       <= ff1_in;
         fb0_ff       <= fb0_in;
         fb1_ff       <= fb1_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      w0_ff         <= w0_in;
      res_ff        <= res_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_saturated  = rsp_sat_ff;

   a_mac_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> (state_ff == ST_MUL))
      else $error("multiplier finished outside the multiply state");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_LOAD && term_ff == TERM_A1 && !sec_ff))
      else $error("accepted transaction did not start section 0");

   a_term_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (term_ff <= TERM_B2))
      else $error("term counter out of range");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid || !rsp_stall)) |=> (rsp_valid && state_ff == ST_IDLE))
      else $error("finished result not moved to the output register");

endmodule
